/* rtl/rpzp_pkg.sv */
// Shared types, constants and the sine table builder for the rotate/project/plot block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rpzp_pkg;

	// Frame, fixed-point and angle geometry
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 64;
	localparam int FRAC_BITS   = 14;
	localparam int ANGLE_STEPS = 1024;

	localparam int STORE_CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int STORE_AW    = $clog2(STORE_CELLS);
	localparam int ANGLE_AW    = $clog2(ANGLE_STEPS);
	localparam int QUARTER     = ANGLE_STEPS / 4;
	localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
	localparam int HEIGHT_W    = $clog2(MAX_HEIGHT + 1);
	localparam int AREA_W      = $clog2(STORE_CELLS + 1);

	// Datapath widths
	localparam int TRIG_W  = FRAC_BITS + 2;
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = TRIG_W;
	localparam int ACC_W   = MUL_A_W + MUL_B_W;
	localparam int UV_W    = 24;
	localparam int COORD_W = 26;
	localparam int NUM_W   = MUL_A_W;
	localparam int DEN_W   = COORD_W;
	localparam int DEPTH_W = 24;
	localparam int GLYPH_W = 8;

	localparam logic [DEPTH_W-1:0] DEPTH_FAR   = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_SAT   = 24'hFFFFFE;
	localparam logic [GLYPH_W-1:0] GLYPH_RESET = 8'd46;

	// Angle constants in Q30
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;

	// Register map of the configuration port
	typedef enum logic [2:0] {
		CFG_ANGLE_A,
		CFG_ANGLE_B,
		CFG_ANGLE_C,
		CFG_VIEW_DIST,
		CFG_FOCAL,
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_BG_GLYPH
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_PLOT,
		KIND_CLEAR,
		KIND_READ,
		KIND_NONE
	} kind_t;

	typedef enum logic [2:0] {
		ST_DRAWN,
		ST_HIDDEN,
		ST_OFF,
		ST_BEHIND,
		ST_CLEARED,
		ST_READ
	} status_t;

	// Trig register slots, sin/cos of each angle
	typedef enum logic [2:0] {
		TRIG_SA,
		TRIG_CA,
		TRIG_SB,
		TRIG_CB,
		TRIG_SC,
		TRIG_CC
	} trig_sel_t;

	// Multiplier operations; the accumulate step follows in the cycle after issue
	typedef enum logic [4:0] {
		MUL_NOP,
		MUL_JSA,
		MUL_KCA,
		MUL_JCA,
		MUL_KSA,
		MUL_ICB,
		MUL_ISB,
		MUL_SBU,
		MUL_CBU,
		MUL_SCV,
		MUL_CCW,
		MUL_CCV,
		MUL_SCW,
		MUL_MCC,
		MUL_MSC,
		MUL_WZ,
		MUL_KX,
		MUL_HZ,
		MUL_KY,
		MUL_WH,
		MUL_YW
	} mul_op_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [7:0]         point_x;
		logic signed [7:0]         point_y;
		logic signed [7:0]         point_z;
		logic [GLYPH_W-1:0]        glyph;
		logic [13:0]               read_index;
	} in_word_t;

	typedef struct packed {
		logic [2:0]                status;
		logic [13:0]               cell_index;
		logic [GLYPH_W-1:0]        cell_glyph;
	} out_word_t;

	// Controller to datapath
	typedef struct packed {
		logic                      load;
		logic                      rom_rd;
		trig_sel_t                 rom_sel;
		mul_op_t                   mul;
		logic                      round;
		logic                      zt;
		logic                      div_start;
		logic                      mem_rd;
		logic                      mem_wr;
		logic                      glyph_rd;
		logic                      sweep;
		logic                      sweep_init;
		logic [STORE_AW-1:0]       sweep_addr;
		logic                      out_load;
		status_t                   res;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0]                kind;
		logic                      zt_pos;
		logic                      div_done;
		logic                      idx_ok;
		logic                      nearer;
		logic                      out_free;
	} dp_stat_t;

	typedef logic signed [TRIG_W-1:0] trig_rom_t [ANGLE_STEPS];

	// Q1.F sine of a Q30 angle in [0, 2pi), odd Taylor series summed in Q30
	function automatic logic signed [TRIG_W-1:0] sin_q(input longint th_in);
		longint      th;
		logic        neg;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		th  = th_in;
		neg = 1'b0;
		if (th >= PI_Q30) begin
			th  = th - PI_Q30;
			neg = 1'b1;
		end
		if (th > HALF_PI_Q30) th = PI_Q30 - th;
		x    = 64'(th);
		x2   = (x * x) >> 30;
		term = x;
		sum  = th;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) != 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		sum = (sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (neg) sum = -sum;
		return TRIG_W'(sum);
	endfunction

	// Full-turn sine table, built at elaboration
	function automatic trig_rom_t build_sin_rom();
		trig_rom_t rom;
		longint    th;
		for (int n = 0; n < ANGLE_STEPS; n++) begin
			th     = (longint'(n) * TWO_PI_Q30 + ANGLE_STEPS / 2) / ANGLE_STEPS;
			rom[n] = sin_q(th);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

/* rtl/rpzp_div.sv */
// Iterative signed-by-positive divider, one quotient bit per cycle, truncating.
// Depends on rpzp_pkg for NUM_W and DEN_W.
`timescale 1ns / 1ps
`default_nettype none

module rpzp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [rpzp_pkg::NUM_W-1:0]  num,
	input  logic [rpzp_pkg::DEN_W-1:0]         den,
	output logic signed [rpzp_pkg::NUM_W-1:0]  quo,
	output logic                               done
);
	import rpzp_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic                busy_q;
	logic                done_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_W-1:0]    mag_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W:0]      trial;
	logic                fits;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, mag_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// magnitude shift register doubles as quotient
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			mag_q <= {mag_q[NUM_W-2:0], fits};
		end
	end

	assign quo  = neg_q ? -$signed(mag_q) : $signed(mag_q);
	assign done = done_q;

endmodule

`default_nettype wire

/* rtl/rpzp_ctrl.sv */
// Controller state machine: sequences trig fetch, rotation, projection, divide and store access.
// Depends on rpzp_pkg for command/status structs and codes.
`timescale 1ns / 1ps
`default_nettype none

module rpzp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output rpzp_pkg::dp_cmd_t    cmd,
	input  rpzp_pkg::dp_stat_t   stat
);
	import rpzp_pkg::*;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_TRIG,
		S_MUL,
		S_ROUND,
		S_ZT,
		S_ZCHK,
		S_PROJ,
		S_DIVGO,
		S_DIVWAIT,
		S_IDX,
		S_IDXACT,
		S_RANGE,
		S_MRD,
		S_MWR,
		S_RDMEM,
		S_CLEAR,
		S_DONE
	} state_t;

	localparam logic [STORE_AW-1:0] LAST_CELL = STORE_AW'(STORE_CELLS - 1);

	state_t               state_q;
	logic [STORE_AW-1:0]  cnt_q;
	status_t              res_q;

	// rotation program; one step past the last product lets it accumulate
	function automatic mul_op_t rot_prog(input logic [3:0] step);
		mul_op_t op;
		unique case (step)
			4'd0:    op = MUL_JSA;
			4'd1:    op = MUL_KCA;
			4'd2:    op = MUL_JCA;
			4'd3:    op = MUL_KSA;
			4'd4:    op = MUL_ICB;
			4'd5:    op = MUL_ISB;
			4'd6:    op = MUL_SBU;
			4'd7:    op = MUL_CBU;
			4'd8:    op = MUL_SCV;
			4'd9:    op = MUL_CCW;
			4'd10:   op = MUL_CCV;
			4'd11:   op = MUL_SCW;
			4'd12:   op = MUL_MCC;
			4'd13:   op = MUL_MSC;
			default: op = MUL_NOP;
		endcase
		return op;
	endfunction

	// projection numerators and frame area
	function automatic mul_op_t proj_prog(input logic [2:0] step);
		mul_op_t op;
		unique case (step)
			3'd0:    op = MUL_WZ;
			3'd1:    op = MUL_KX;
			3'd2:    op = MUL_HZ;
			3'd3:    op = MUL_KY;
			3'd4:    op = MUL_WH;
			default: op = MUL_NOP;
		endcase
		return op;
	endfunction

	assign in_ready = (state_q == S_IDLE);

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.mul        = MUL_NOP;
		cmd.rom_sel    = trig_sel_t'(cnt_q[2:0]);
		cmd.sweep_addr = cnt_q;
		cmd.res        = res_q;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep      = 1'b1;
				cmd.sweep_init = 1'b1;
			end
			S_IDLE:    cmd.load = in_valid;
			S_TRIG:    cmd.rom_rd = 1'b1;
			S_MUL:     cmd.mul = rot_prog(cnt_q[3:0]);
			S_ROUND:   cmd.round = 1'b1;
			S_ZT:      cmd.zt = 1'b1;
			S_PROJ:    cmd.mul = proj_prog(cnt_q[2:0]);
			S_DIVGO:   cmd.div_start = 1'b1;
			S_IDX:     cmd.mul = MUL_YW;
			S_MRD:     cmd.mem_rd = 1'b1;
			S_MWR:     cmd.mem_wr = 1'b1;
			S_RDMEM:   cmd.glyph_rd = 1'b1;
			S_CLEAR:   cmd.sweep = 1'b1;
			S_DONE:    cmd.out_load = stat.out_free;
			default: begin
			end
		endcase
	end

	// state, step counter and result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= '0;
			res_q   <= ST_DRAWN;
		end else begin
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					cnt_q <= '0;
					unique case (kind_t'(stat.kind))
						KIND_PLOT:  state_q <= S_TRIG;
						KIND_CLEAR: state_q <= S_CLEAR;
						KIND_READ:  state_q <= S_RDMEM;
						KIND_NONE:  state_q <= S_IDLE;
					endcase
				end
				S_TRIG: begin
					if (cnt_q == STORE_AW'(TRIG_CC)) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL: begin
					if (cnt_q == STORE_AW'(14)) begin
						cnt_q   <= '0;
						state_q <= S_ROUND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROUND: state_q <= S_ZT;
				S_ZT:    state_q <= S_ZCHK;
				S_ZCHK: begin
					if (stat.zt_pos) begin
						state_q <= S_PROJ;
					end else begin
						res_q   <= ST_BEHIND;
						state_q <= S_DONE;
					end
				end
				S_PROJ: begin
					if (cnt_q == STORE_AW'(5)) begin
						cnt_q   <= '0;
						state_q <= S_DIVGO;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIVGO: state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (stat.div_done) state_q <= S_IDX;
				end
				S_IDX:    state_q <= S_IDXACT;
				S_IDXACT: state_q <= S_RANGE;
				S_RANGE: begin
					if (stat.idx_ok) begin
						state_q <= S_MRD;
					end else begin
						res_q   <= ST_OFF;
						state_q <= S_DONE;
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					res_q   <= stat.nearer ? ST_DRAWN : ST_HIDDEN;
					state_q <= S_DONE;
				end
				S_RDMEM: begin
					res_q   <= ST_READ;
					state_q <= S_DONE;
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) begin
						res_q   <= ST_CLEARED;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/rpzp_datapath.sv */
// Datapath: config registers, sine ROM, shared multiplier, two dividers, glyph and depth stores,
// output register. Depends on rpzp_pkg and rpzp_div.
`timescale 1ns / 1ps
`default_nettype none

module rpzp_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [2:0]            cfg_index,
	input  logic [9:0]            cfg_data,
	input  rpzp_pkg::in_word_t    in_data,
	input  rpzp_pkg::dp_cmd_t     cmd,
	output rpzp_pkg::dp_stat_t    stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rpzp_pkg::out_word_t   out_data
);
	import rpzp_pkg::*;

	localparam trig_rom_t SIN_ROM = build_sin_rom();
	localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(1) <<< (2 * FRAC_BITS - 1);
	localparam logic signed [COORD_W-1:0] SAT_Z    = COORD_W'(DEPTH_SAT);

	// configuration registers
	logic [ANGLE_AW-1:0]  angle_a_q, angle_b_q, angle_c_q;
	logic [9:0]           view_dist_q;
	logic [7:0]           focal_q;
	logic [8:0]           width_q;
	logic [6:0]           height_q;
	logic [GLYPH_W-1:0]   bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_a_q   <= '0;
			angle_b_q   <= '0;
			angle_c_q   <= '0;
			view_dist_q <= 10'd100;
			focal_q     <= 8'd40;
			width_q     <= 9'd160;
			height_q    <= 7'd44;
			bg_q        <= GLYPH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ANGLE_A:   angle_a_q   <= ANGLE_AW'(cfg_data);
				CFG_ANGLE_B:   angle_b_q   <= ANGLE_AW'(cfg_data);
				CFG_ANGLE_C:   angle_c_q   <= ANGLE_AW'(cfg_data);
				CFG_VIEW_DIST: view_dist_q <= cfg_data;
				CFG_FOCAL:     focal_q     <= cfg_data[7:0];
				CFG_WIDTH:     width_q     <= cfg_data[8:0];
				CFG_HEIGHT:    height_q    <= cfg_data[6:0];
				CFG_BG_GLYPH:  bg_q        <= cfg_data[7:0];
			endcase
		end
	end

	// frame size saturated into the store's range
	logic [WIDTH_W-1:0]  w_cl;
	logic [HEIGHT_W-1:0] h_cl;

	always_comb begin
		if (width_q == '0) w_cl = WIDTH_W'(1);
		else if (int'(width_q) > MAX_WIDTH) w_cl = WIDTH_W'(MAX_WIDTH);
		else w_cl = WIDTH_W'(width_q);
		if (height_q == '0) h_cl = HEIGHT_W'(1);
		else if (int'(height_q) > MAX_HEIGHT) h_cl = HEIGHT_W'(MAX_HEIGHT);
		else h_cl = HEIGHT_W'(height_q);
	end

	// input word
	in_word_t in_q;

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_data;
	end

	// sine ROM: cos is the same table a quarter turn on
	logic signed [TRIG_W-1:0] trig_q [6];
	logic [ANGLE_AW-1:0]      rom_ang;
	logic [ANGLE_AW-1:0]      rom_addr;

	always_comb begin
		unique case (cmd.rom_sel)
			TRIG_SA, TRIG_CA: rom_ang = angle_a_q;
			TRIG_SB, TRIG_CB: rom_ang = angle_b_q;
			default:          rom_ang = angle_c_q;
		endcase
		rom_addr = cmd.rom_sel[0] ? rom_ang + ANGLE_AW'(QUARTER) : rom_ang;
	end

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) trig_q[cmd.rom_sel] <= SIN_ROM[rom_addr];
	end

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [ACC_W-1:0]   mul_prod;
	logic signed [ACC_W-1:0]   p_s1;
	mul_op_t                   mul_s1;

	logic signed [UV_W-1:0]    u_q, v_q, w1_q;
	logic signed [MUL_A_W-1:0] m_q;
	logic signed [ACC_W-1:0]   x_q, y_q, z_q;
	logic signed [COORD_W-1:0] xr_q, yr_q, zr_q, zt_q;
	logic signed [NUM_W-1:0]   nx_q, ny_q;
	logic [AREA_W-1:0]         area_q;
	logic signed [ACC_W-1:0]   idx_q;
	logic signed [NUM_W-1:0]   qx, qy;
	logic                      dx_done, dy_done;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul)
			MUL_JSA: begin mul_a = MUL_A_W'(in_q.point_y); mul_b = trig_q[TRIG_SA]; end
			MUL_KCA: begin mul_a = MUL_A_W'(in_q.point_z); mul_b = trig_q[TRIG_CA]; end
			MUL_JCA: begin mul_a = MUL_A_W'(in_q.point_y); mul_b = trig_q[TRIG_CA]; end
			MUL_KSA: begin mul_a = MUL_A_W'(in_q.point_z); mul_b = trig_q[TRIG_SA]; end
			MUL_ICB: begin mul_a = MUL_A_W'(in_q.point_x); mul_b = trig_q[TRIG_CB]; end
			MUL_ISB: begin mul_a = MUL_A_W'(in_q.point_x); mul_b = trig_q[TRIG_SB]; end
			MUL_SBU: begin mul_a = MUL_A_W'(u_q);  mul_b = trig_q[TRIG_SB]; end
			MUL_CBU: begin mul_a = MUL_A_W'(u_q);  mul_b = trig_q[TRIG_CB]; end
			MUL_SCV: begin mul_a = MUL_A_W'(v_q);  mul_b = trig_q[TRIG_SC]; end
			MUL_CCW: begin mul_a = MUL_A_W'(w1_q); mul_b = trig_q[TRIG_CC]; end
			MUL_CCV: begin mul_a = MUL_A_W'(v_q);  mul_b = trig_q[TRIG_CC]; end
			MUL_SCW: begin mul_a = MUL_A_W'(w1_q); mul_b = trig_q[TRIG_SC]; end
			MUL_MCC: begin mul_a = m_q; mul_b = trig_q[TRIG_CC]; end
			MUL_MSC: begin mul_a = m_q; mul_b = trig_q[TRIG_SC]; end
			MUL_WZ: begin
				mul_a = MUL_A_W'(zt_q);
				mul_b = $signed(MUL_B_W'(w_cl >> 1));
			end
			MUL_KX: begin
				mul_a = MUL_A_W'(xr_q);
				mul_b = $signed(MUL_B_W'({focal_q, 1'b0}));
			end
			MUL_HZ: begin
				mul_a = MUL_A_W'(zt_q);
				mul_b = $signed(MUL_B_W'(h_cl >> 1));
			end
			MUL_KY: begin
				mul_a = MUL_A_W'(yr_q);
				mul_b = $signed(MUL_B_W'(focal_q));
			end
			MUL_WH: begin
				mul_a = $signed(MUL_A_W'(w_cl));
				mul_b = $signed(MUL_B_W'(h_cl));
			end
			MUL_YW: begin
				mul_a = qy;
				mul_b = $signed(MUL_B_W'(w_cl));
			end
			default: begin
			end
		endcase
		mul_prod = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_s1 <= MUL_NOP;
		else mul_s1 <= cmd.mul;
	end

	always_ff @(posedge clk) begin
		p_s1 <= mul_prod;
	end

	// accumulate the product issued in the previous cycle
	always_ff @(posedge clk) begin
		unique case (mul_s1)
			MUL_JSA: u_q  <= UV_W'(p_s1);
			MUL_KCA: u_q  <= u_q - UV_W'(p_s1);
			MUL_JCA: v_q  <= UV_W'(p_s1);
			MUL_KSA: v_q  <= v_q + UV_W'(p_s1);
			MUL_ICB: w1_q <= UV_W'(p_s1);
			MUL_ISB: z_q  <= p_s1 <<< (2 * FRAC_BITS);
			MUL_SBU: m_q  <= MUL_A_W'(p_s1);
			MUL_CBU: z_q  <= z_q - (p_s1 <<< FRAC_BITS);
			MUL_SCV: x_q  <= p_s1 <<< FRAC_BITS;
			MUL_CCW: x_q  <= x_q + (p_s1 <<< FRAC_BITS);
			MUL_CCV: y_q  <= p_s1 <<< FRAC_BITS;
			MUL_SCW: y_q  <= y_q - (p_s1 <<< FRAC_BITS);
			MUL_MCC: x_q  <= x_q + p_s1;
			MUL_MSC: y_q  <= y_q - p_s1;
			MUL_WZ:  nx_q <= NUM_W'(p_s1);
			MUL_KX:  nx_q <= nx_q + NUM_W'(p_s1);
			MUL_HZ:  ny_q <= NUM_W'(p_s1);
			MUL_KY:  ny_q <= ny_q + NUM_W'(p_s1);
			MUL_WH:  area_q <= AREA_W'(p_s1);
			MUL_YW:  idx_q <= p_s1 + ACC_W'(qx);
			default: begin
			end
		endcase
	end

	// round Q3F sums half up to QF, then push away by the view distance
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			xr_q <= COORD_W'((x_q + RND_HALF) >>> (2 * FRAC_BITS));
			yr_q <= COORD_W'((y_q + RND_HALF) >>> (2 * FRAC_BITS));
			zr_q <= COORD_W'((z_q + RND_HALF) >>> (2 * FRAC_BITS));
		end
		if (cmd.zt) zt_q <= zr_q + $signed(COORD_W'({view_dist_q, FRAC_BITS'(0)}));
	end

	// screen coordinates by truncating division
	rpzp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (nx_q),
		.den    (DEN_W'(zt_q)),
		.quo    (qx),
		.done   (dx_done)
	);

	rpzp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (ny_q),
		.den    (DEN_W'(zt_q)),
		.quo    (qy),
		.done   (dy_done)
	);

	// depth key and store compare
	logic [DEPTH_W-1:0]  depth_key;
	logic [DEPTH_W-1:0]  dq_q;
	logic [GLYPH_W-1:0]  gq_q;
	logic [STORE_AW-1:0] cell_addr;
	logic                nearer;

	assign depth_key = (zt_q > SAT_Z) ? DEPTH_SAT : DEPTH_W'(zt_q);
	assign cell_addr = idx_q[STORE_AW-1:0];
	assign nearer    = depth_key < dq_q;

	// glyph and depth stores, one write and one read port each
	logic [GLYPH_W-1:0]  glyph_mem [STORE_CELLS];
	logic [DEPTH_W-1:0]  depth_mem [STORE_CELLS];
	logic                wr_en;
	logic [STORE_AW-1:0] wr_addr;
	logic [GLYPH_W-1:0]  wr_glyph;
	logic [DEPTH_W-1:0]  wr_depth;

	always_comb begin
		wr_en    = cmd.sweep || (cmd.mem_wr && nearer);
		wr_addr  = cmd.sweep ? cmd.sweep_addr : cell_addr;
		wr_glyph = cmd.sweep ? (cmd.sweep_init ? GLYPH_RESET : bg_q) : in_q.glyph;
		wr_depth = cmd.sweep ? DEPTH_FAR : depth_key;
	end

	always_ff @(posedge clk) begin
		if (wr_en) glyph_mem[wr_addr] <= wr_glyph;
		if (cmd.glyph_rd) gq_q <= glyph_mem[STORE_AW'(in_q.read_index)];
	end

	always_ff @(posedge clk) begin
		if (wr_en) depth_mem[wr_addr] <= wr_depth;
		if (cmd.mem_rd) dq_q <= depth_mem[cell_addr];
	end

	// output register
	logic      out_valid_q;
	out_word_t out_q;
	logic      read_in_store;

	assign read_in_store = int'(in_q.read_index) < STORE_CELLS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status <= cmd.res;
			unique case (cmd.res)
				ST_DRAWN, ST_HIDDEN: out_q.cell_index <= 14'(idx_q);
				ST_READ:             out_q.cell_index <= in_q.read_index;
				default:             out_q.cell_index <= '0;
			endcase
			out_q.cell_glyph <= (cmd.res == ST_READ && read_in_store) ? gq_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to controller
	always_comb begin
		stat.kind     = in_q.kind;
		stat.zt_pos   = !zt_q[COORD_W-1] && (zt_q != '0);
		stat.div_done = dx_done && dy_done;
		stat.idx_ok   = !idx_q[ACC_W-1] && (idx_q < $signed(ACC_W'(area_q)));
		stat.nearer   = nearer;
		stat.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

/* rtl/rotate_project_zbuffer_plot.sv */
// Top level of the rotate/project/z-buffer point plotter: controller plus datapath.
// Depends on rpzp_pkg, rpzp_ctrl, rpzp_datapath (and rpzp_div below it).
//
//   channel  | signals                            | direction
//   ---------+------------------------------------+----------
//   cfg      | cfg_valid cfg_ready cfg_index/data | in (write only, always ready)
//   in       | in_valid in_ready in_data          | in
//   out      | out_valid out_ready out_data       | out
//
// A plot word's time is set mostly by the two 40-step dividers and the 15-step
// rotation sequence on the one shared multiplier. A clear sweeps all STORE_CELLS
// (16384) cells, one cell per cycle.
// After reset a sweep over all 16384 cells loads both stores; in_ready stays low until it ends.
// One word is processed at a time; a finished word waits in the output register
// while the next input word is already accepted and processed.
`timescale 1ns / 1ps
`default_nettype none

module rotate_project_zbuffer_plot (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [9:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rpzp_pkg::in_word_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rpzp_pkg::out_word_t   out_data
);
	import rpzp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	rpzp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	rpzp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* tb/sv/rotate_project_zbuffer_plot_tb.sv */
// Self-checking testbench for rotate_project_zbuffer_plot: plot, clear and read words
// checked against an in-bench z-buffer predictor under several register settings.
// Depends on rpzp_pkg and the RTL top level.
`timescale 1ns / 1ps

module rotate_project_zbuffer_plot_tb;
	import rpzp_pkg::*;

	localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef enum logic [1:0] {JOB_WORD, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t  op;
		in_word_t   word;
		cfg_idx_t   reg_idx;
		logic [9:0] reg_val;
		int         send_idle;
		int         recv_stall;
	} job_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;

	rotate_project_zbuffer_plot DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Clock: 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state
	longint      sine_q [ANGLE_STEPS];
	longint      cosine_q [ANGLE_STEPS];
	logic [7:0]  glyph_mem [STORE_CELLS];
	logic [23:0] depth_mem [STORE_CELLS];
	longint      reg_file [8];

	job_t        pending_jobs [$];
	out_word_t   expected_words [$];
	int          phase_idle, phase_stall;
	int          errors, cycles, drain_cnt, recv_stall;
	int          n_plot, n_drawn, n_hidden, n_off, n_behind, n_clear, n_read;
	bit          in_acc, cfg_acc;

	// Q1.14 sine of a Q30 angle in [0, 2pi)
	function automatic longint sine_of(input longint th_in);
		longint      th, acc;
		logic        neg;
		logic [63:0] xv, x2, term;
		th  = th_in;
		neg = 1'b0;
		if (th >= PI_Q30) begin
			th  = th - PI_Q30;
			neg = 1'b1;
		end
		if (th > HALF_PI_Q30) th = PI_Q30 - th;
		xv   = th;
		x2   = (xv * xv) >> 30;
		term = xv;
		acc  = th;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		acc = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		return neg ? -acc : acc;
	endfunction

	function automatic longint reg_mask(input cfg_idx_t idx);
		case (idx)
			CFG_FOCAL, CFG_BG_GLYPH: return 64'hFF;
			CFG_WIDTH:               return 64'h1FF;
			CFG_HEIGHT:              return 64'h7F;
			default:                 return 64'h3FF;
		endcase
	endfunction

	function automatic void fill_frame();
		for (int c = 0; c < STORE_CELLS; c++) begin
			glyph_mem[c] = reg_file[CFG_BG_GLYPH][7:0];
			depth_mem[c] = '1;
		end
	endfunction

	// Expected result of one input word; returns 0 when the word is ignored
	function automatic bit predict_word(input in_word_t w, output out_word_t r);
		longint xi, yj, zk, sa, ca, sb, cb, sc, cc, xr, yr, zr, zt, wd, ht, kf;
		longint xp, yp, idx, key;
		r = '0;
		case (w.kind)
			KIND_NONE: return 1'b0;
			KIND_CLEAR: begin
				fill_frame();
				r.status = ST_CLEARED;
				n_clear++;
			end
			KIND_READ: begin
				r.status     = ST_READ;
				r.cell_index = w.read_index;
				r.cell_glyph = glyph_mem[w.read_index];
				n_read++;
			end
			default: begin
				n_plot++;
				xi = w.point_x; yj = w.point_y; zk = w.point_z;
				sa = sine_q[reg_file[CFG_ANGLE_A]]; ca = cosine_q[reg_file[CFG_ANGLE_A]];
				sb = sine_q[reg_file[CFG_ANGLE_B]]; cb = cosine_q[reg_file[CFG_ANGLE_B]];
				sc = sine_q[reg_file[CFG_ANGLE_C]]; cc = cosine_q[reg_file[CFG_ANGLE_C]];
				wd = reg_file[CFG_WIDTH] < 1 ? 1 : (reg_file[CFG_WIDTH] > MAX_WIDTH ?
					MAX_WIDTH : reg_file[CFG_WIDTH]);
				ht = reg_file[CFG_HEIGHT] < 1 ? 1 : (reg_file[CFG_HEIGHT] > MAX_HEIGHT ?
					MAX_HEIGHT : reg_file[CFG_HEIGHT]);
				kf = reg_file[CFG_FOCAL];
				xr = yj*sa*sb*cc - zk*ca*sb*cc + (yj*ca*sc + zk*sa*sc + xi*cb*cc) * ONE_Q;
				yr = (yj*ca*cc + zk*sa*cc - xi*cb*sc) * ONE_Q - yj*sa*sb*sc + zk*ca*sb*sc;
				zr = (zk*ca*cb - yj*sa*cb) * ONE_Q + xi*sb*ONE_Q*ONE_Q;
				// round half up from Q42 to Q14; >>> on longint floors
				xr = (xr + (64'sd1 <<< 27)) >>> 28;
				yr = (yr + (64'sd1 <<< 27)) >>> 28;
				zr = (zr + (64'sd1 <<< 27)) >>> 28;
				zt = zr + reg_file[CFG_VIEW_DIST] * ONE_Q;
				if (zt <= 0) begin
					r.status = ST_BEHIND;
					n_behind++;
				end else begin
					xp  = ((wd / 2) * zt + 2 * kf * xr) / zt;
					yp  = ((ht / 2) * zt + kf * yr) / zt;
					idx = xp + yp * wd;
					if (idx < 0 || idx >= wd * ht) begin
						r.status = ST_OFF;
						n_off++;
					end else begin
						key = zt > 64'hFFFFFE ? 64'hFFFFFE : zt;
						r.cell_index = idx[13:0];
						if (key < depth_mem[idx]) begin
							depth_mem[idx] = key[23:0];
							glyph_mem[idx] = w.glyph;
							r.status = ST_DRAWN;
							n_drawn++;
						end else begin
							r.status = ST_HIDDEN;
							n_hidden++;
						end
					end
				end
			end
		endcase
		return 1'b1;
	endfunction

	// Stimulus builders
	task automatic add_word(input kind_t k, input int x, input int y, input int z,
			input int g, input int ri);
		job_t j;
		j.op = JOB_WORD;
		j.word.kind = k;
		j.word.point_x = x[7:0];
		j.word.point_y = y[7:0];
		j.word.point_z = z[7:0];
		j.word.glyph = g[7:0];
		j.word.read_index = ri[13:0];
		j.reg_idx = CFG_ANGLE_A;
		j.reg_val = '0;
		j.send_idle = phase_idle;
		j.recv_stall = phase_stall;
		pending_jobs.push_back(j);
	endtask

	task automatic add_cfg(input cfg_idx_t idx, input int v);
		job_t j;
		j.op = JOB_CFG;
		j.word = '0;
		j.reg_idx = idx;
		j.reg_val = v[9:0];
		j.send_idle = phase_idle;
		j.recv_stall = phase_stall;
		pending_jobs.push_back(j);
	endtask

	task automatic add_drain();
		job_t j;
		j.op = JOB_DRAIN;
		j.word = '0;
		j.reg_idx = CFG_ANGLE_A;
		j.reg_val = '0;
		j.send_idle = phase_idle;
		j.recv_stall = phase_stall;
		pending_jobs.push_back(j);
	endtask

	// Driver: all inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_stall);
			if (!(in_valid && !in_acc) && !(cfg_valid && !cfg_acc)) begin
				if (pending_jobs.size() == 0) begin
					in_valid  <= 1'b0;
					cfg_valid <= 1'b0;
				end else begin
					case (pending_jobs[0].op)
						JOB_DRAIN: begin
							in_valid  <= 1'b0;
							cfg_valid <= 1'b0;
							drain_cnt = (expected_words.size() == 0) ? drain_cnt + 1 : 0;
							if (drain_cnt >= 150) begin
								drain_cnt = 0;
								void'(pending_jobs.pop_front());
							end
						end
						JOB_CFG: begin
							in_valid  <= 1'b0;
							cfg_valid <= 1'b1;
							cfg_index <= pending_jobs[0].reg_idx;
							cfg_data  <= pending_jobs[0].reg_val;
							void'(pending_jobs.pop_front());
						end
						default: begin
							cfg_valid <= 1'b0;
							recv_stall = pending_jobs[0].recv_stall;
							if ($urandom_range(99) < pending_jobs[0].send_idle) begin
								in_valid <= 1'b0;
							end else begin
								in_valid <= 1'b1;
								in_data  <= pending_jobs[0].word;
								void'(pending_jobs.pop_front());
							end
						end
					endcase
				end
			end
		end
	end

	// Monitor: accepted words, register writes and result checking
	always @(posedge clk) begin
		out_word_t got_exp, pred;
		if (arst_n) begin
			in_acc  = in_valid && in_ready;
			cfg_acc = cfg_valid && cfg_ready;
			if (cfg_acc)
				reg_file[cfg_index] = longint'(cfg_data) & reg_mask(cfg_idx_t'(cfg_index));
			if (in_acc && predict_word(in_data, pred))
				expected_words.push_back(pred);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, actual %p", $time, out_data);
				end else begin
					got_exp = expected_words.pop_front();
					if (got_exp.status !== out_data.status)
						$display("%0t: status mismatch, expected %0d actual %0d", $time,
							got_exp.status, out_data.status);
					if (got_exp.cell_index !== out_data.cell_index)
						$display("%0t: cell_index mismatch, expected %0d actual %0d", $time,
							got_exp.cell_index, out_data.cell_index);
					if (got_exp.cell_glyph !== out_data.cell_glyph)
						$display("%0t: cell_glyph mismatch, expected %0d actual %0d", $time,
							got_exp.cell_glyph, out_data.cell_glyph);
					if (got_exp !== out_data) errors++;
				end
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** rotate_project_zbuffer_plot: FAILED **");
			$finish;
		end
	end

	initial begin
		longint th, tc;
		int     r, w_now, h_now, clears_left;
		for (int n = 0; n < ANGLE_STEPS; n++) begin
			th = (longint'(n) * TWO_PI_Q30 + ANGLE_STEPS / 2) / ANGLE_STEPS;
			tc = th + HALF_PI_Q30;
			if (tc >= TWO_PI_Q30) tc = tc - TWO_PI_Q30;
			sine_q[n]   = sine_of(th);
			cosine_q[n] = sine_of(tc);
		end
		reg_file = '{0, 0, 0, 100, 40, 160, 44, 46};
		fill_frame();

		// Directed: reset settings, extremes, depth tie, ignored kind
		phase_idle = 0;
		phase_stall = 0;
		add_word(KIND_PLOT, 0, 0, 0, 65, 0);
		add_word(KIND_PLOT, 0, 0, 0, 66, 0);
		add_word(KIND_READ, 0, 0, 0, 0, 3600);
		add_word(KIND_PLOT, 127, 127, 127, 255, 16383);
		add_word(KIND_PLOT, -128, -128, -128, 0, 0);
		add_word(KIND_PLOT, 127, -128, 0, 170, 0);
		add_word(KIND_PLOT, -128, 127, -1, 85, 0);
		add_word(KIND_READ, 0, 0, 0, 0, 0);
		add_word(KIND_READ, 0, 0, 0, 0, 16383);
		add_word(KIND_READ, 0, 0, 0, 0, 14'h2AAA);
		add_word(KIND_READ, 0, 0, 0, 0, 14'h1555);
		add_word(KIND_NONE, -1, -1, -1, 255, 16383);
		// behind the viewer, including zt of exactly zero
		add_drain();
		add_cfg(CFG_VIEW_DIST, 0);
		add_word(KIND_PLOT, 0, 0, -5, 1, 0);
		add_word(KIND_PLOT, 0, 0, 0, 2, 0);
		add_word(KIND_PLOT, 0, 0, 5, 3, 0);
		// off screen with wide focal scale
		add_drain();
		add_cfg(CFG_FOCAL, 255);
		add_cfg(CFG_VIEW_DIST, 1);
		add_word(KIND_PLOT, 127, 0, 0, 4, 0);
		add_word(KIND_PLOT, -128, -128, 1, 5, 0);
		// clear with a new background, then read back
		add_drain();
		add_cfg(CFG_BG_GLYPH, 255);
		add_word(KIND_CLEAR, 0, 0, 0, 0, 0);
		add_word(KIND_READ, 0, 0, 0, 0, 3600);

		// Random phases with varying registers, idling and output stalls
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin phase_idle = 0;  phase_stall = 0;  end
				1: begin phase_idle = 68; phase_stall = 0;  end
				2: begin phase_idle = 0;  phase_stall = 68; end
				default: begin phase_idle = 23; phase_stall = 23; end
			endcase
			add_drain();
			if (p == 1) begin
				add_cfg(CFG_ANGLE_A, 0); add_cfg(CFG_ANGLE_B, 0); add_cfg(CFG_ANGLE_C, 0);
				add_cfg(CFG_VIEW_DIST, 0); add_cfg(CFG_FOCAL, 0);
				add_cfg(CFG_WIDTH, 1); add_cfg(CFG_HEIGHT, 1); add_cfg(CFG_BG_GLYPH, 0);
				w_now = 1; h_now = 1;
			end else if (p == 2) begin
				add_cfg(CFG_ANGLE_A, 1023); add_cfg(CFG_ANGLE_B, 1023);
				add_cfg(CFG_ANGLE_C, 1023); add_cfg(CFG_VIEW_DIST, 1023);
				add_cfg(CFG_FOCAL, 255); add_cfg(CFG_WIDTH, 511);
				add_cfg(CFG_HEIGHT, 127); add_cfg(CFG_BG_GLYPH, 255);
				w_now = 256; h_now = 64;
			end else if (p == 5) begin
				add_cfg(CFG_WIDTH, 0); add_cfg(CFG_HEIGHT, 0);
				add_cfg(CFG_VIEW_DIST, $urandom_range(20, 300));
				w_now = 1; h_now = 1;
			end else begin
				add_cfg(CFG_ANGLE_A, $urandom_range(1023));
				add_cfg(CFG_ANGLE_B, $urandom_range(1023));
				add_cfg(CFG_ANGLE_C, $urandom_range(1023));
				add_cfg(CFG_VIEW_DIST, $urandom_range(20, 400));
				add_cfg(CFG_FOCAL, $urandom_range(255));
				w_now = (p == 3) ? 256 : $urandom_range(1, 300);
				h_now = (p == 3) ? 64 : $urandom_range(1, 90);
				add_cfg(CFG_WIDTH, w_now);
				add_cfg(CFG_HEIGHT, h_now);
				add_cfg(CFG_BG_GLYPH, $urandom_range(255));
				if (w_now > 256) w_now = 256;
				if (h_now > 64) h_now = 64;
			end
			clears_left = 1;
			for (int n = 0; n < 235; ) begin
				r = $urandom_range(99);
				if (r < 3) begin
					add_word(KIND_NONE, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), $urandom_range(255), $urandom_range(16383));
				end else begin
					n++;
					if (r < 4 && clears_left > 0) begin
						clears_left--;
						add_word(KIND_CLEAR, $urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(255), $urandom_range(16383));
					end else if (r < 20) begin
						add_word(KIND_READ, $urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(255),
							(r < 12) ? $urandom_range(w_now * h_now - 1)
								: $urandom_range(16383));
					end else if (r < 50) begin
						// tight cluster so cells get hit again and depth ties happen
						add_word(KIND_PLOT, $urandom_range(8) - 4, $urandom_range(8) - 4,
							$urandom_range(8) - 4, $urandom_range(255), $urandom_range(16383));
					end else begin
						add_word(KIND_PLOT, $urandom_range(255), $urandom_range(255),
							$urandom_range(255), $urandom_range(255), $urandom_range(16383));
					end
					if (n == 120) add_drain();
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		wait (pending_jobs.size() == 0 && !in_valid && expected_words.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d plots (%0d drawn, %0d hidden, %0d off screen, %0d behind),",
			n_plot, n_drawn, n_hidden, n_off, n_behind);
		$display("%0d reads and %0d clears over 12 register settings.", n_read, n_clear);
		if (errors == 0 && expected_words.size() == 0)
			$display("** rotate_project_zbuffer_plot: PASSED **");
		else
			$display("** rotate_project_zbuffer_plot: FAILED **");
		$finish;
	end

endmodule
